// ===== rtl/lmqc_pkg.sv =====
// ----------------------------------------------------------------------------
// lmqc_pkg
// Shared constants and types for the LLC with MSHR quotas.
// ----------------------------------------------------------------------------
package lmqc_pkg;

   localparam int NUM_SETS    = 256;
   localparam int NUM_WAYS    = 8;
   localparam int LINE_BYTES  = 64;
   localparam int MSHR_COUNT  = 16;
   localparam int CORE_COUNT  = 8;

   localparam int OFF_W  = $clog2(LINE_BYTES);
   localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int SETB   = $clog2(NUM_SETS);
   localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int MSHR_W = (MSHR_COUNT > 1) ? $clog2(MSHR_COUNT) : 1;
   localparam int LINE_W = 32 - OFF_W;
   localparam int TAG_W  = (LINE_W - SETB > 0) ? LINE_W - SETB : 1;
   localparam int RANK_W = WAY_W;
   localparam int CNT_W  = 5;
   localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

   // one way's entry in the set memory
   typedef struct packed {
      logic              valid;
      logic              dirty;
      logic              ready;
      logic [RANK_W-1:0] rank;
      logic [TAG_W-1:0]  tag;
   } way_type;

   localparam int WAY_BITS = $bits(way_type);
   localparam int SET_BITS = WAY_BITS * NUM_WAYS;

   typedef logic [2:0] status_type;
   localparam status_type ST_HIT        = 3'd0;
   localparam status_type ST_MERGED     = 3'd1;
   localparam status_type ST_ALLOC      = 3'd2;
   localparam status_type ST_QUOTA      = 3'd3;
   localparam status_type ST_NO_MSHR    = 3'd4;
   localparam status_type ST_NO_WAY     = 3'd5;
   localparam status_type ST_FILL_MATCH = 3'd6;
   localparam status_type ST_FILL_MISS  = 3'd7;

   localparam logic [0:0] CSR_MASK   = 1'b0;
   localparam logic [0:0] CSR_QUOTAS = 1'b1;

   // MSHR lookup result passed to the cache pipeline
   typedef struct packed {
      logic              found;
      logic [MSHR_W-1:0] found_idx;
      logic [WAY_W-1:0]  found_way;
      logic              free;
      logic [MSHR_W-1:0] free_idx;
   } mshr_look_type;

   // MSHR update from the cache pipeline
   typedef struct packed {
      logic              alloc;
      logic              release_en;
      logic [MSHR_W-1:0] idx;
      logic [LINE_W-1:0] line;
      logic [WAY_W-1:0]  way;
   } mshr_upd_type;

endpackage

// ===== rtl/lmqc_ram.sv =====
// ----------------------------------------------------------------------------
// lmqc_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmqc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/lmqc_mshr.sv =====
// ----------------------------------------------------------------------------
// lmqc_mshr
// MSHR file: CAM lookup by line, lowest free entry, allocate and release.
// ----------------------------------------------------------------------------
module lmqc_mshr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [lmqc_pkg::LINE_W-1:0] look_line,
   output lmqc_pkg::mshr_look_type    look,
   input  lmqc_pkg::mshr_upd_type     upd
);

   logic [lmqc_pkg::MSHR_COUNT-1:0] valid_ff;
   logic [lmqc_pkg::MSHR_COUNT-1:0] valid_in;
   logic [lmqc_pkg::LINE_W-1:0]     line_ff [lmqc_pkg::MSHR_COUNT];
   logic [lmqc_pkg::WAY_W-1:0]      way_ff  [lmqc_pkg::MSHR_COUNT];

   always_comb begin
      look = '0;
      for (int i = lmqc_pkg::MSHR_COUNT - 1; i >= 0; i--) begin
         if (valid_ff[i] && line_ff[i] == look_line) begin
            look.found     = 1'b1;
            look.found_idx = lmqc_pkg::MSHR_W'(i);
            look.found_way = way_ff[i];
         end
         if (!valid_ff[i]) begin
            look.free     = 1'b1;
            look.free_idx = lmqc_pkg::MSHR_W'(i);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (upd.alloc) begin
         valid_in[upd.idx] = 1'b1;
      end
      if (upd.release_en) begin
         valid_in[upd.idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      if (upd.alloc) begin
         line_ff[upd.idx] <= upd.line;
         way_ff[upd.idx]  <= upd.way;
      end
   end

endmodule

// ===== rtl/llc_mshr_core_quota_cache_core.sv =====
// ----------------------------------------------------------------------------
// llc_mshr_core_quota_cache_core
// Set-associative LRU LLC with MSHRs and per-core MSHR quotas.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/ready    | kind address is_write core_id core_valid
//  rsp     | out       | rsp_valid/ready    | status read_* writeback_*
//  csr     | in        | csr_write_enable   | csr_index csr_write_data
//
// Each item passes through the set memory read, then the read-modify-write
// of the whole set (tags, state, LRU ranks) in one row; no new request is taken meanwhile.
// After reset the set memory is swept, one set a cycle, through all NUM_SETS sets,
// while no request is taken. A result held by rsp_ready blocks the next read;
// a new request is taken in the same cycle the pending result transfers.
// ----------------------------------------------------------------------------
module llc_mshr_core_quota_cache_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [31:0] req_address,
   input  logic        req_is_write,
   input  logic [2:0]  req_core_id,
   input  logic        req_core_valid,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic        rsp_read_valid,
   output logic [31:0] rsp_read_address,
   output logic        rsp_writeback_valid,
   output logic [31:0] rsp_writeback_address,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [63:0] csr_write_data
);

   localparam int NW = lmqc_pkg::NUM_WAYS;

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_EXEC  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [lmqc_pkg::SET_W:0]  clr_ff, clr_in;
   logic [7:0]  mask_ff;
   logic [63:0] quotas_ff;
   logic [lmqc_pkg::CNT_W-1:0] cnt_ff [lmqc_pkg::CORE_COUNT];

   logic        kind_ff, wr_ff, hc_ff;
   logic [2:0]  core_ff;
   logic [lmqc_pkg::LINE_W-1:0] line_ff;
   logic        rv_ff, rrv_ff, rwv_ff;
   lmqc_pkg::status_type st_ff;
   logic [31:0] ra_ff, wa_ff;

   logic [lmqc_pkg::SET_BITS-1:0] rd_row, wr_row;
   logic wr_en;
   logic [lmqc_pkg::SET_W-1:0] wr_addr, rd_addr;

   lmqc_pkg::mshr_look_type look;
   lmqc_pkg::mshr_upd_type  upd;

   logic [lmqc_pkg::SET_W-1:0] set_of_ff;
   logic [lmqc_pkg::TAG_W-1:0] tag_of_ff;

   logic [lmqc_pkg::SET_W-1:0] req_set;
   logic [lmqc_pkg::LINE_W-1:0] req_line;

   assign req_line = req_address[31:lmqc_pkg::OFF_W];
   generate
      if (lmqc_pkg::SETB > 0) begin : g_set
         assign req_set   = req_line[lmqc_pkg::SET_W-1:0];
         assign set_of_ff = line_ff[lmqc_pkg::SET_W-1:0];
      end else begin : g_noset
         assign req_set   = '0;
         assign set_of_ff = '0;
      end
   endgenerate
   assign tag_of_ff = lmqc_pkg::TAG_W'(line_ff >> lmqc_pkg::SETB);

   assign req_ready = (state_ff == S_IDLE) && (!rv_ff || rsp_ready);
   assign rd_addr   = req_set;

   lmqc_ram #(.WIDTH(lmqc_pkg::SET_BITS), .DEPTH(lmqc_pkg::NUM_SETS)) u_sets (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_row),
      .rd_addr(rd_addr),
      .rd_data(rd_row)
   );

   lmqc_mshr u_mshr (
      .clock    (clock),
      .reset    (reset),
      .look_line(line_ff),
      .look     (look),
      .upd      (upd)
   );

   // execute stage
   lmqc_pkg::way_type ways [NW];
   lmqc_pkg::way_type nways [NW];
   lmqc_pkg::status_type st_c;
   logic rd_c, wb_c, inc_c, dec_c, do_wr;
   logic [31:0] wa_c;
   logic [lmqc_pkg::WAY_W-1:0] hit_w, free_w, vic_w, aw;
   logic hit_f, free_f, vic_f;
   logic [lmqc_pkg::RANK_W-1:0] vic_age, old;
   logic [7:0] quota;
   logic [lmqc_pkg::CNT_W-1:0] ccnt;

   always_comb begin
      for (int i = 0; i < NW; i++) begin
         ways[i] = lmqc_pkg::way_type'(rd_row[i*lmqc_pkg::WAY_BITS +: lmqc_pkg::WAY_BITS]);
      end
      nways = ways;
      st_c = lmqc_pkg::ST_HIT;
      rd_c = 1'b0; wb_c = 1'b0; inc_c = 1'b0; dec_c = 1'b0; do_wr = 1'b0;
      wa_c = '0;
      upd = '0;
      upd.line = line_ff;
      hit_f = 1'b0; hit_w = '0; free_f = 1'b0; free_w = '0;
      vic_f = 1'b0; vic_w = '0; vic_age = '0; old = '0; aw = '0;
      quota = quotas_ff[core_ff*8 +: 8];
      ccnt  = cnt_ff[core_ff];
      for (int i = NW - 1; i >= 0; i--) begin
         if (ways[i].valid && ways[i].ready && ways[i].tag == tag_of_ff) begin
            hit_f = 1'b1; hit_w = lmqc_pkg::WAY_W'(i);
         end
         if (!ways[i].valid) begin
            free_f = 1'b1; free_w = lmqc_pkg::WAY_W'(i);
         end
      end
      for (int i = 0; i < NW; i++) begin
         if (ways[i].valid && ways[i].ready && (!vic_f || ways[i].rank > vic_age)) begin
            vic_f = 1'b1; vic_w = lmqc_pkg::WAY_W'(i); vic_age = ways[i].rank;
         end
      end
      if (kind_ff) begin
         if (!look.found) begin
            st_c = lmqc_pkg::ST_FILL_MISS;
         end else begin
            st_c = lmqc_pkg::ST_FILL_MATCH;
            nways[look.found_way].ready = 1'b1;
            do_wr = 1'b1;
            upd.release_en = 1'b1;
            upd.idx = look.found_idx;
            dec_c = hc_ff && (ccnt != '0);
         end
      end else if (hit_f) begin
         st_c = lmqc_pkg::ST_HIT;
         do_wr = 1'b1;
         old = ways[hit_w].rank;
         for (int i = 0; i < NW; i++) begin
            if (i != int'(hit_w) && ways[i].valid && ways[i].rank < old) begin
               nways[i].rank = ways[i].rank + 1'b1;
            end
         end
         nways[hit_w].rank = '0;
         if (wr_ff) nways[hit_w].dirty = 1'b1;
      end else if (look.found) begin
         st_c = lmqc_pkg::ST_MERGED;
         if (wr_ff) begin
            nways[look.found_way].dirty = 1'b1;
            do_wr = 1'b1;
         end
      end else if (hc_ff && mask_ff[core_ff] && ({3'b0, ccnt} >= quota)) begin
         st_c = lmqc_pkg::ST_QUOTA;
      end else if (!look.free) begin
         st_c = lmqc_pkg::ST_NO_MSHR;
      end else if (!free_f && !vic_f) begin
         st_c = lmqc_pkg::ST_NO_WAY;
      end else begin
         st_c = lmqc_pkg::ST_ALLOC;
         do_wr = 1'b1;
         aw = free_f ? free_w : vic_w;
         if (!free_f) begin
            old = ways[vic_w].rank;
            if (ways[vic_w].dirty) begin
               wb_c = 1'b1;
               if (lmqc_pkg::SETB == 0) begin
                  wa_c = 32'({ways[vic_w].tag, lmqc_pkg::OFF_W'(0)});
               end else begin
                  wa_c = 32'({ways[vic_w].tag, set_of_ff, lmqc_pkg::OFF_W'(0)});
               end
            end
            for (int i = 0; i < NW; i++) begin
               if (i != int'(vic_w) && ways[i].valid && ways[i].rank > old) begin
                  nways[i].rank = ways[i].rank - 1'b1;
               end
            end
         end
         // insert as youngest; others age
         for (int i = 0; i < NW; i++) begin
            if (i != int'(aw) && nways[i].valid && !(i == int'(vic_w) && !free_f)) begin
               nways[i].rank = nways[i].rank + 1'b1;
            end
         end
         nways[aw].valid = 1'b1;
         nways[aw].dirty = wr_ff;
         nways[aw].ready = 1'b0;
         nways[aw].rank  = '0;
         nways[aw].tag   = tag_of_ff;
         upd.alloc = 1'b1;
         upd.idx   = look.free_idx;
         upd.way   = aw;
         rd_c  = 1'b1;
         inc_c = hc_ff && (ccnt < lmqc_pkg::COUNT_MAX);
      end
      if (state_ff != S_EXEC) begin
         upd.alloc = 1'b0; upd.release_en = 1'b0; do_wr = 1'b0;
         inc_c = 1'b0; dec_c = 1'b0;
      end
   end

   always_comb begin
      wr_row = '0;
      for (int i = 0; i < NW; i++) begin
         wr_row[i*lmqc_pkg::WAY_BITS +: lmqc_pkg::WAY_BITS] = nways[i];
      end
      wr_en   = do_wr;
      wr_addr = set_of_ff;
      if (state_ff == S_CLEAR) begin
         wr_row  = '0;
         wr_en   = 1'b1;
         wr_addr = clr_ff[lmqc_pkg::SET_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (lmqc_pkg::SET_W+1)'(lmqc_pkg::NUM_SETS - 1)) state_in = S_IDLE;
         end
         S_IDLE:  if (req_valid && req_ready) state_in = S_EXEC;
         S_EXEC:  state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         rv_ff     <= 1'b0;
         mask_ff   <= '0;
         quotas_ff <= '0;
         for (int c = 0; c < lmqc_pkg::CORE_COUNT; c++) cnt_ff[c] <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (csr_write_enable) begin
            if (csr_index == lmqc_pkg::CSR_MASK) mask_ff <= csr_write_data[7:0];
            else quotas_ff <= csr_write_data;
         end
         if (inc_c) cnt_ff[core_ff] <= ccnt + 1'b1;
         if (dec_c) cnt_ff[core_ff] <= ccnt - 1'b1;
         if (state_ff == S_EXEC) rv_ff <= 1'b1;
         else if (rsp_ready) rv_ff <= 1'b0;
      end
      if (req_valid && req_ready) begin
         kind_ff <= req_kind;
         wr_ff   <= req_is_write;
         core_ff <= req_core_id;
         hc_ff   <= req_core_valid && (32'(req_core_id) < lmqc_pkg::CORE_COUNT);
         line_ff <= req_line;
      end
      if (state_ff == S_EXEC) begin
         st_ff  <= st_c;
         rrv_ff <= rd_c;
         ra_ff  <= rd_c ? {line_ff, lmqc_pkg::OFF_W'(0)} : 32'd0;
         rwv_ff <= wb_c;
         wa_ff  <= wa_c;
      end
   end

   assign rsp_valid             = rv_ff;
   assign rsp_status            = st_ff;
   assign rsp_read_valid        = rrv_ff;
   assign rsp_read_address      = ra_ff;
   assign rsp_writeback_valid   = rwv_ff;
   assign rsp_writeback_address = wa_ff;

endmodule
